// File: rtl/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg: shared constants for the response deframer
// Header layout, magic prefix and result kind codes.
// ----------------------------------------------------------------------------
package ard_pkg;

  // Header layout, in byte positions from the start of a response.
  localparam int unsigned HdrBytes   = 13;
  localparam int unsigned MagicBytes = 4;
  localparam int unsigned FlagPos    = 4;
  localparam int unsigned LenPos     = 5;
  localparam int unsigned LenEnd     = 9;

  localparam logic [7:0] FLAG_GOOD = 8'h01;

  // Result kinds.
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_EMPTY     = 2'd1;
  localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
  localparam logic [1:0] KIND_BAD_FLAG  = 2'd3;

  // Expected magic byte at a header position ("ZBXD").
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = 8'h5A;
      2'd1:    b = 8'h42;
      2'd2:    b = 8'h58;
      default: b = 8'h44;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/agent_response_deframer_core.sv
// ----------------------------------------------------------------------------
// agent_response_deframer_core: length-prefixed response deframer
// Parses a 13-byte header and streams the payload bytes that follow it.
// ----------------------------------------------------------------------------
// Feed one request per cycle: either a received byte (action 0) or the start
// of a new response (action 1), which clears all parse state and gives no
// result. The first 13 bytes of a response form the header: magic "ZBXD", a
// flag byte that must be 1, a 32-bit little-endian payload length, and four
// reserved bytes. On the 13th byte the header is judged: bad magic wins over
// bad flag, a zero length reports an empty frame, and each of these reports
// carries last = 1 and payload_byte = 0. A good header with a nonzero length
// switches to payload mode, where every byte comes out as kind 0 and the
// final one carries last = 1. After any report or the last payload byte,
// bytes are dropped silently until the next new-response request. The block
// sustains one request per cycle while results are read without stalls; a
// request is captured in the input register when it is accepted, and its
// result is loaded into the result register when the input register advances.
// The parse state and the result register sit in one stage, so in_ready_o
// falls only while a result is held unread and the input register is also
// full.
// ----------------------------------------------------------------------------
module agent_response_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);
  import ard_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  localparam logic [3:0] HDR_LAST   = 4'(HdrBytes - 1);
  localparam logic [3:0] MAGIC_END  = 4'(MagicBytes);
  localparam logic [3:0] FLAG_AT    = 4'(FlagPos);
  localparam logic [3:0] LEN_START  = 4'(LenPos);
  localparam logic [3:0] LEN_STOP   = 4'(LenEnd);

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic       s1_action_q;
  logic [7:0] s1_byte_q;

  // Parse state.
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic        magic_ok_q, magic_ok_d;
  logic        flag_ok_q, flag_ok_d;
  logic [31:0] len_q, len_d;
  logic [31:0] remain_q, remain_d;

  // Result register.
  logic       out_valid_q, out_valid_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] pbyte_q, pbyte_d;
  logic       last_q, last_d;

  logic       s1_adv;
  logic       s1_fire;
  logic       in_fire;
  logic       produce;
  logic [1:0] lane;

  // Stage 1 may advance when the result register is empty or being read.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign lane       = 2'(hdr_cnt_q - LEN_START);

  always_comb begin
    s1_valid_d = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  end

  // Parse one request and build its result, if any.
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    magic_ok_d = magic_ok_q;
    flag_ok_d  = flag_ok_q;
    len_d      = len_q;
    remain_d   = remain_q;
    produce    = 1'b0;
    kind_d     = kind_q;
    pbyte_d    = pbyte_q;
    last_d     = last_q;

    if (s1_fire) begin
      if (s1_action_q) begin
        // New response: back to the reset state, no result.
        phase_d    = PH_HEADER;
        hdr_cnt_d  = '0;
        magic_ok_d = 1'b1;
        flag_ok_d  = 1'b1;
        len_d      = '0;
        remain_d   = '0;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            if (hdr_cnt_q < MAGIC_END) begin
              if (s1_byte_q != magic_byte(hdr_cnt_q[1:0])) begin
                magic_ok_d = 1'b0;
              end
            end else if (hdr_cnt_q == FLAG_AT) begin
              flag_ok_d = (s1_byte_q == FLAG_GOOD);
            end else if (hdr_cnt_q >= LEN_START && hdr_cnt_q < LEN_STOP) begin
              len_d[{lane, 3'b000} +: 8] = len_q[{lane, 3'b000} +: 8] | s1_byte_q;
            end

            if (hdr_cnt_q != HDR_LAST) begin
              hdr_cnt_d = hdr_cnt_q + 4'd1;
            end else begin
              // Judge the header: magic first, then flag, then length.
              hdr_cnt_d = 4'(HdrBytes);
              pbyte_d   = '0;
              last_d    = 1'b1;
              priority if (!magic_ok_d) begin
                produce = 1'b1;
                kind_d  = KIND_BAD_MAGIC;
                phase_d = PH_DONE;
              end else if (!flag_ok_d) begin
                produce = 1'b1;
                kind_d  = KIND_BAD_FLAG;
                phase_d = PH_DONE;
              end else if (len_d == '0) begin
                produce = 1'b1;
                kind_d  = KIND_EMPTY;
                phase_d = PH_DONE;
              end else begin
                remain_d = len_d;
                phase_d  = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            produce = 1'b1;
            kind_d  = KIND_DATA;
            pbyte_d = s1_byte_q;
            last_d  = (remain_q <= 32'd1);
            if (remain_q != '0) begin
              remain_d = remain_q - 32'd1;
            end
            if (remain_d == '0) begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            // Done, or the unused code: drop the byte.
          end
        endcase
      end
    end

    out_valid_d = produce ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      magic_ok_q  <= 1'b1;
      flag_ok_q   <= 1'b1;
      len_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      magic_ok_q  <= magic_ok_d;
      flag_ok_q   <= flag_ok_d;
      len_q       <= len_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_i;
      s1_byte_q   <= data_byte_i;
    end
    if (produce) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign payload_byte_o = pbyte_q;
  assign last_o         = last_q;

  // Payload mode always has at least one byte left to pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> remain_q != '0)
    else $error("payload phase with no bytes remaining");

  // Header collection never runs past the last header byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> hdr_cnt_q <= HDR_LAST)
    else $error("header count out of range");

  // Every report is terminal and carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != KIND_DATA |-> last_q && pbyte_q == '0)
    else $error("report without last or with nonzero byte");

  // A held result blocks stage 1 from advancing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q && out_valid_q)
    else $error("request lost while result was stalled");

  // A new-response request restarts header collection.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_action_q |=> phase_q == PH_HEADER && hdr_cnt_q == '0)
    else $error("restart did not clear parse state");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for agent_response_deframer_core
// Streams framed responses through the deframer with random gaps and output
// stalls, and compares every result with an in-bench model of the parser.
// ----------------------------------------------------------------------------
module testbench;
  import ard_pkg::*;

  // Request actions.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_NEW  = 1'b1;

  localparam logic [31:0] GOOD_MAGIC   = 32'h5A42_5844;  // "ZBXD", first byte on top
  localparam int unsigned ItemTarget   = 1750;
  localparam int unsigned CalmItems    = 250;
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PrintLimit   = 40;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } parse_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic       last;
  } deframe_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_q  = 1'b0;
  logic       action_q    = ACT_BYTE;
  logic [7:0] data_q      = 8'h00;
  logic       out_ready_q = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] payload_byte_o;
  logic       last_o;

  // Model of the parser state.
  parse_phase_e parse_phase;
  logic [3:0]   hdr_count;
  logic         magic_good;
  logic         flag_good;
  logic [31:0]  len_word;
  logic [31:0]  bytes_left;

  deframe_result_t pending_results[$];
  int unsigned     requests_sent = 0;
  int unsigned     error_count   = 0;
  bit              calm          = 1'b0;  // no gaps and no stalls while set

  agent_response_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_q),
    .in_ready_o     (in_ready_o),
    .action_i       (action_q),
    .data_byte_i    (data_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_q),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PrintLimit) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  task automatic clear_parser();
    parse_phase = PH_HEADER;
    hdr_count   = '0;
    magic_good  = 1'b1;
    flag_good   = 1'b1;
    len_word    = '0;
    bytes_left  = '0;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] b, input logic last);
    pending_results.push_back('{kind: kind, payload: b, last: last});
  endtask

  // Terminal header verdict: report and stop until the next new response.
  task automatic push_verdict(input logic [1:0] kind);
    push_result(kind, 8'h00, 1'b1);
    parse_phase = PH_DONE;
  endtask

  task automatic predict_response(input logic act, input logic [7:0] b);
    int unsigned pos;
    if (act == ACT_NEW) begin
      clear_parser();
      return;
    end
    case (parse_phase)
      PH_HEADER: begin
        pos = hdr_count;
        if (pos < MagicBytes) begin
          if (b != GOOD_MAGIC[31 - 8*pos -: 8]) magic_good = 1'b0;
        end else if (pos == FlagPos) begin
          flag_good = (b == FLAG_GOOD);
        end else if (pos >= LenPos && pos < LenEnd) begin
          len_word |= 32'(b) << (8 * (pos - LenPos));
        end
        if (pos + 1 < HdrBytes) begin
          hdr_count = 4'(pos + 1);
        end else begin
          // Judge the header: magic fault wins over flag fault.
          hdr_count = 4'(HdrBytes);
          if (!magic_good) push_verdict(KIND_BAD_MAGIC);
          else if (!flag_good) push_verdict(KIND_BAD_FLAG);
          else if (len_word == 0) push_verdict(KIND_EMPTY);
          else begin
            bytes_left  = len_word;
            parse_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        push_result(KIND_DATA, b, bytes_left <= 1);
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) parse_phase = PH_DONE;
      end
      default: ;  // done: drop the byte
    endcase
  endtask

  task automatic check_result();
    deframe_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind=%0d byte=%02h last=%0b",
                                kind_o, payload_byte_o, last_o));
      return;
    end
    want = pending_results.pop_front();
    if (kind_o !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
    if (payload_byte_o !== want.payload)
      report_mismatch($sformatf("payload_byte %02h, want %02h", payload_byte_o, want.payload));
    if (last_o !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
  endtask

  // Watch both handshakes at every edge. Predict first so that an expectation
  // always exists before its result can show up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_q && in_ready_o) predict_response(action_q, data_q);
      if (out_valid_o && out_ready_q) check_result();
    end
  end

  // Output back-pressure: hold ready low for random stretches.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold != 0 && !calm) begin
        hold--;
        out_ready_q <= 1'b0;
      end else begin
        out_ready_q <= 1'b1;
        hold = 0;
        if ($urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Drop valid only when a gap follows, so that valid never falls and rises
  // in the same step. Return at the edge that accepts the request.
  task automatic send_req(input logic act, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    action_q   <= act;
    data_q     <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    requests_sent++;
  endtask

  function automatic logic [7:0] header_byte(input logic [31:0] magic, input logic [7:0] flag,
                                             input logic [31:0] len, input int unsigned pos);
    if (pos < MagicBytes) return magic[31 - 8*pos -: 8];
    if (pos == FlagPos) return flag;
    if (pos < LenEnd) return len[8*(pos - LenPos) +: 8];
    return 8'($urandom);  // reserved bytes carry anything
  endfunction

  // Send the first nbytes of a header, optionally preceded by a new response.
  task automatic send_header(input bit with_new, input logic [31:0] magic,
                             input logic [7:0] flag, input logic [31:0] len,
                             input int unsigned nbytes = HdrBytes);
    if (with_new) send_req(ACT_NEW, 8'($urandom));
    for (int unsigned i = 0; i < nbytes; i++) send_req(ACT_BYTE, header_byte(magic, flag, len, i));
  endtask

  task automatic send_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_req(ACT_BYTE, 8'($urandom));
  endtask

  // One random response. Most are well formed with random content; the rest
  // carry header faults, huge lengths cut short, or plain noise.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned n;
    int unsigned tail;
    logic [31:0] magic;
    logic [7:0]  flag;
    logic [31:0] len;
    pick  = $urandom_range(0, 99);
    magic = GOOD_MAGIC;
    flag  = FLAG_GOOD;
    len   = $urandom_range(1, 24);
    n     = len;
    tail  = $urandom_range(0, 2);
    if (pick < 10) begin
      len = '0;
      n   = 0;
    end else if (pick < 22) begin
      magic[8*$urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(0, 2) == 0) magic ^= $urandom;
      if ($urandom_range(0, 1) == 0) flag = 8'($urandom);
      n = 0;
    end else if (pick < 32) begin
      do flag = 8'($urandom); while (flag == FLAG_GOOD);
      n = 0;
    end else if (pick < 40) begin
      // Length far beyond what the run can stream; abandon it early.
      len  = $urandom | 32'h0001_0000;
      n    = $urandom_range(0, 6);
      tail = 0;
    end else if (pick < 46) begin
      // Truncated header followed by mixed noise.
      send_header(1'b1, magic, flag, $urandom, $urandom_range(0, 12));
      repeat ($urandom_range(1, 16)) begin
        send_req(($urandom_range(0, 5) == 0) ? ACT_NEW : ACT_BYTE, 8'($urandom));
      end
      return;
    end
    send_header(1'b1, magic, flag, len);
    send_bytes(n);
    send_bytes(tail);  // trailing bytes after completion are dropped
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_good_frames();
    // Straight after reset the parser already collects a header.
    send_header(1'b0, GOOD_MAGIC, FLAG_GOOD, 32'd1);
    send_req(ACT_BYTE, 8'hFF);
    send_header(1'b1, GOOD_MAGIC, FLAG_GOOD, 32'd2);
    send_req(ACT_BYTE, 8'h00);
    send_req(ACT_BYTE, 8'hFF);
    send_req(ACT_BYTE, 8'hA5);
  endtask

  task automatic test_header_faults();
    send_header(1'b1, GOOD_MAGIC, FLAG_GOOD, 32'd0);          // empty frame
    send_header(1'b1, ~GOOD_MAGIC, 8'hFE, 32'd3);             // both faults: magic wins
    send_header(1'b1, GOOD_MAGIC ^ 32'h1, FLAG_GOOD, 32'd1);  // last magic byte off
    send_req(ACT_BYTE, 8'h44);
    send_header(1'b1, GOOD_MAGIC, 8'h00, 32'd5);              // bad flag
    send_header(1'b1, GOOD_MAGIC, 8'hFF, 32'hFFFF_FFFF);      // bad flag, all length bits set
  endtask

  task automatic test_restart();
    send_header(1'b1, GOOD_MAGIC, FLAG_GOOD, 32'd7, 6);       // abandon mid-header
    send_header(1'b1, GOOD_MAGIC, FLAG_GOOD, 32'd3);
    send_req(ACT_BYTE, 8'h11);                                // abandon mid-payload
    send_header(1'b1, GOOD_MAGIC, FLAG_GOOD, 32'hFFFF_FFFF);  // full 32-bit length
    send_bytes(3);
    send_req(ACT_NEW, 8'hFF);
    send_header(1'b1, GOOD_MAGIC, FLAG_GOOD, 32'd1);
    send_req(ACT_BYTE, 8'h5A);
  endtask

  // Full rate on both sides: no request gaps and no output stalls.
  task automatic test_back_to_back();
    int unsigned stop_at;
    stop_at = requests_sent + CalmItems;
    calm = 1'b1;
    while (requests_sent < stop_at) send_random_frame();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (requests_sent < ItemTarget) send_random_frame();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    clear_parser();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_good_frames();
    test_header_faults();
    test_restart();
    test_back_to_back();
    test_random_traffic();

    // Stop requesting, drain outstanding results, then let the pipe settle
    // so that any stray late result is still caught.
    in_valid_q <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ard_pkg.sv
rtl/agent_response_deframer_core.sv
test/testbench.sv
